>>> hdl/crfb_delta_sigma_modulator_unit_defines.svh
// assertion macros for the modulator
`ifndef CRFB_DELTA_SIGMA_MODULATOR_UNIT_DEFINES_SVH
`define CRFB_DELTA_SIGMA_MODULATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define CRFB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crfb check failed");

// next-cycle implication
`define CRFB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crfb check failed");

`endif

>>> hdl/crfb_pkg.sv
package crfb_pkg;

  localparam int MAX_ORDER    = 9;
  localparam int SAMPLE_WIDTH = 24;
  localparam int COEF_WIDTH   = 32;
  localparam int STATE_WIDTH  = 48;
  localparam int NUM_COEF     = 2 * MAX_ORDER + 1 + MAX_ORDER / 2;
  localparam int A_BASE       = 0;
  localparam int B_BASE       = MAX_ORDER;
  localparam int G_BASE       = 2 * MAX_ORDER + 1;
  localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;
  localparam int GAIN_WIDTH   = 18;
  localparam int CFG_WIDTH    = 18;

  // input modes
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_COEF   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_FILTER_ORDER = 2'd0;
  localparam logic [1:0] REG_INPUT_GAIN   = 2'd1;

  localparam logic signed [47:0] ST_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] ST_MIN = {1'b1, {47{1'b0}}};
  localparam logic signed [47:0] V_POS  = 48'sd1 <<< FRAC_BITS;

  typedef enum logic [3:0] {
    C_IDLE, C_GAIN, C_RD, C_EX, C_HI, C_LO, C_TRUNC, C_ACC, C_PACK
  } ctl_e;

  typedef enum logic [4:0] {
    SP_DEC_LD, SP_DEC_MU, SP_DEC_BIT,
    SP_E_LD, SP_E_ADD, SP_E_BU, SP_E_AV, SP_E_GI, SP_E_ST,
    SP_O_LD, SP_O_ADD, SP_O_BU, SP_O_AV, SP_O_ST,
    SP_Z_LD, SP_Z_BU, SP_Z_AV, SP_Z_ST
  } step_e;

  typedef enum logic [2:0] {K_LOAD, K_ADD, K_MUL, K_STORE, K_BIT} kind_e;

  typedef enum logic [1:0] {X_U, X_V, X_I} xsel_e;

  typedef enum logic [3:0] {
    MC_NONE, MC_GAIN, MC_LOAD, MC_ADDI, MC_LATCH, MC_HI, MC_LO, MC_TRUNC, MC_ACC
  } mac_cmd_e;

  typedef struct packed {
    mac_cmd_e cmd;
    xsel_e    xsel;
    logic     neg;
  } mac_ctrl_t;

  // saturate a widened sum to the integrator width
  function automatic logic signed [47:0] sat_state(logic signed [54:0] v);
    logic signed [47:0] r;
    if (v > 55'(ST_MAX)) r = ST_MAX;
    else if (v < 55'(ST_MIN)) r = ST_MIN;
    else r = v[47:0];
    return r;
  endfunction

endpackage

>>> hdl/crfb_ram.sv
module crfb_ram #(
  parameter int DEPTH = 9,
  parameter int WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rdata_q;
  logic             rvalid_q;

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // entry valid bits, unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

>>> hdl/crfb_mac.sv
module crfb_mac (
  input  logic                     clk_i,
  input  crfb_pkg::mac_ctrl_t      ctrl_i,
  input  logic signed [23:0]       sample_i,
  input  logic signed [17:0]       gain_i,
  input  logic                     bit_i,
  input  logic signed [47:0]       int_data_i,
  input  logic signed [31:0]       coef_data_i,
  output logic signed [47:0]       acc_o
);

  logic signed [27:0] u_q;
  logic signed [47:0] acc_q;
  logic signed [47:0] x_q;
  logic signed [31:0] c_q;
  logic signed [55:0] ph_q;
  logic signed [56:0] pl_q;
  logic signed [53:0] term_q;

  logic signed [41:0] gp;
  logic        [41:0] gmag;
  logic        [27:0] umag;
  logic signed [27:0] u_d;
  logic signed [47:0] x_d;
  logic signed [79:0] full;
  logic signed [52:0] q;

  // scaled sample, truncated toward zero
  always_comb begin
    gp   = sample_i * gain_i;
    gmag = gp[41] ? 42'(-gp) : 42'(gp);
    umag = gmag[41:14];
    u_d  = gp[41] ? -$signed(umag) : $signed(umag);
  end

  // multiplier operand select
  always_comb begin
    case (ctrl_i.xsel)
      crfb_pkg::X_U: x_d = 48'(u_q);
      crfb_pkg::X_V: x_d = bit_i ? crfb_pkg::V_POS : -crfb_pkg::V_POS;
      default:       x_d = int_data_i;
    endcase
  end

  // recombine partial products, shift with truncation toward zero
  always_comb begin
    full = (80'(ph_q) <<< 24) + 80'(pl_q);
    q    = full[79:27];
    if (full[79] && (full[26:0] != '0)) begin
      q = q + 53'sd1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      crfb_pkg::MC_GAIN:  u_q <= u_d;
      crfb_pkg::MC_LOAD:  acc_q <= int_data_i;
      crfb_pkg::MC_ADDI:  acc_q <= crfb_pkg::sat_state(55'(acc_q) + 55'(int_data_i));
      crfb_pkg::MC_LATCH: begin
        x_q <= x_d;
        c_q <= coef_data_i;
      end
      crfb_pkg::MC_HI:    ph_q <= $signed(x_q[47:24]) * c_q;
      crfb_pkg::MC_LO:    pl_q <= $signed({1'b0, x_q[23:0]}) * c_q;
      crfb_pkg::MC_TRUNC: term_q <= ctrl_i.neg ? -54'(q) : 54'(q);
      crfb_pkg::MC_ACC:   acc_q <= crfb_pkg::sat_state(55'(acc_q) + 55'(term_q));
      default: ;
    endcase
  end

  assign acc_o = acc_q;

endmodule

>>> hdl/crfb_delta_sigma_modulator_unit.sv
// channel  direction  handshake               payload
// in       input      in_valid_i/in_stall_o   mode_i sample_i coef_index_i coef_value_i
// out      output     out_valid_o/out_stall_i packed_byte_o
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i cfg_data_i
//
// coefficient writes, clears and unused modes never stall the input.
// a sample runs a step sequencer over the integrator and coefficient memories
// through one shared multiply-accumulate unit: a product passes the read, latch,
// high, low, truncate and accumulate states, a load or add the read and execute
// states and a store the read state alone; input stalls until the sample packs.
// reset clears control state, integrators and coefficients read as zero.
// a byte waiting under out stall holds only the eighth sample's last cycle.
`include "crfb_delta_sigma_modulator_unit_defines.svh"

module crfb_delta_sigma_modulator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic signed [23:0] sample_i,
  input  logic [4:0]         coef_index_i,
  input  logic signed [31:0] coef_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         packed_byte_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [17:0]        cfg_data_i
);

  crfb_pkg::ctl_e     state_q, state_d;
  crfb_pkg::step_e    step_q, step_n;
  logic [3:0]         pidx_q, pidx_n;
  logic               adv, done;
  logic               bit_q;
  logic [2:0]         bitpos_q;
  logic [7:0]         partial_q;
  logic               out_valid_q;
  logic [7:0]         out_byte_q;
  logic [3:0]         order_q;
  logic signed [17:0] gain_q;
  logic signed [23:0] sample_q;

  logic               in_acc;
  logic [3:0]         ord;
  crfb_pkg::kind_e    kind;
  crfb_pkg::xsel_e    xsel;
  logic               neg;
  logic [3:0]         int_addr;
  logic [4:0]         coef_addr;
  logic               int_we;
  logic               coef_we;
  logic               int_clr;
  crfb_pkg::mac_ctrl_t mctl;
  logic signed [47:0] int_rdata;
  logic signed [31:0] coef_rdata;
  logic signed [47:0] acc;
  logic [7:0]         byte_n;
  logic               emit_ok;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != crfb_pkg::C_IDLE);
  assign cfg_ready_o = 1'b1;
  assign coef_we     = in_acc && (mode_i == crfb_pkg::MODE_COEF) &&
                       (coef_index_i < 5'(crfb_pkg::NUM_COEF));
  assign int_clr     = in_acc && (mode_i == crfb_pkg::MODE_CLEAR);

  // order clamped to the supported range
  always_comb begin
    if (order_q < 4'd2) ord = 4'd2;
    else if (order_q > 4'(crfb_pkg::MAX_ORDER)) ord = 4'(crfb_pkg::MAX_ORDER);
    else ord = order_q;
  end

  // step decode: operation, addresses, operand
  always_comb begin
    kind      = crfb_pkg::K_MUL;
    xsel      = crfb_pkg::X_U;
    neg       = 1'b0;
    int_addr  = pidx_q;
    coef_addr = 5'(crfb_pkg::B_BASE) + {1'b0, pidx_q};
    unique case (step_q)
      crfb_pkg::SP_DEC_LD: begin
        kind = crfb_pkg::K_LOAD;
        int_addr = ord - 4'd1;
      end
      crfb_pkg::SP_DEC_MU: coef_addr = 5'(crfb_pkg::B_BASE) + {1'b0, ord};
      crfb_pkg::SP_DEC_BIT: kind = crfb_pkg::K_BIT;
      crfb_pkg::SP_E_LD:  kind = crfb_pkg::K_LOAD;
      crfb_pkg::SP_E_ADD: begin
        kind = crfb_pkg::K_ADD;
        int_addr = pidx_q - 4'd1;
      end
      crfb_pkg::SP_E_BU: ;
      crfb_pkg::SP_E_AV: begin
        xsel = crfb_pkg::X_V;
        neg = 1'b1;
        coef_addr = 5'(crfb_pkg::A_BASE) + {1'b0, pidx_q};
      end
      crfb_pkg::SP_E_GI: begin
        xsel = crfb_pkg::X_I;
        neg = 1'b1;
        int_addr = pidx_q + 4'd1;
        coef_addr = 5'(crfb_pkg::G_BASE) + {2'b0, pidx_q[3:1]};
      end
      crfb_pkg::SP_E_ST:  kind = crfb_pkg::K_STORE;
      crfb_pkg::SP_O_LD: begin
        kind = crfb_pkg::K_LOAD;
        int_addr = pidx_q + 4'd1;
      end
      crfb_pkg::SP_O_ADD: kind = crfb_pkg::K_ADD;
      crfb_pkg::SP_O_BU:  coef_addr = 5'(crfb_pkg::B_BASE) + {1'b0, pidx_q} + 5'd1;
      crfb_pkg::SP_O_AV: begin
        xsel = crfb_pkg::X_V;
        neg = 1'b1;
        coef_addr = 5'(crfb_pkg::A_BASE) + {1'b0, pidx_q} + 5'd1;
      end
      crfb_pkg::SP_O_ST: begin
        kind = crfb_pkg::K_STORE;
        int_addr = pidx_q + 4'd1;
      end
      crfb_pkg::SP_Z_LD: begin
        kind = crfb_pkg::K_LOAD;
        int_addr = 4'd0;
      end
      crfb_pkg::SP_Z_BU:  coef_addr = 5'(crfb_pkg::B_BASE);
      crfb_pkg::SP_Z_AV: begin
        xsel = crfb_pkg::X_V;
        neg = 1'b1;
        coef_addr = 5'(crfb_pkg::A_BASE);
      end
      crfb_pkg::SP_Z_ST: begin
        kind = crfb_pkg::K_STORE;
        int_addr = 4'd0;
      end
      default: ;
    endcase
  end

  // step order, top pair first
  always_comb begin
    step_n = step_q;
    pidx_n = pidx_q;
    done   = 1'b0;
    unique case (step_q)
      crfb_pkg::SP_DEC_LD:  step_n = crfb_pkg::SP_DEC_MU;
      crfb_pkg::SP_DEC_MU:  step_n = crfb_pkg::SP_DEC_BIT;
      crfb_pkg::SP_DEC_BIT: begin
        step_n = crfb_pkg::SP_E_LD;
        pidx_n = ord - 4'd2;
      end
      crfb_pkg::SP_E_LD:  step_n = (pidx_q == 4'd0) ? crfb_pkg::SP_E_BU : crfb_pkg::SP_E_ADD;
      crfb_pkg::SP_E_ADD: step_n = crfb_pkg::SP_E_BU;
      crfb_pkg::SP_E_BU:  step_n = crfb_pkg::SP_E_AV;
      crfb_pkg::SP_E_AV:  step_n = crfb_pkg::SP_E_GI;
      crfb_pkg::SP_E_GI:  step_n = crfb_pkg::SP_E_ST;
      crfb_pkg::SP_E_ST:  step_n = crfb_pkg::SP_O_LD;
      crfb_pkg::SP_O_LD:  step_n = crfb_pkg::SP_O_ADD;
      crfb_pkg::SP_O_ADD: step_n = crfb_pkg::SP_O_BU;
      crfb_pkg::SP_O_BU:  step_n = crfb_pkg::SP_O_AV;
      crfb_pkg::SP_O_AV:  step_n = crfb_pkg::SP_O_ST;
      crfb_pkg::SP_O_ST: begin
        if (pidx_q >= 4'd2) begin
          step_n = crfb_pkg::SP_E_LD;
          pidx_n = pidx_q - 4'd2;
        end else if (pidx_q == 4'd1) begin
          step_n = crfb_pkg::SP_Z_LD;
        end else begin
          done = 1'b1;
        end
      end
      crfb_pkg::SP_Z_LD: step_n = crfb_pkg::SP_Z_BU;
      crfb_pkg::SP_Z_BU: step_n = crfb_pkg::SP_Z_AV;
      crfb_pkg::SP_Z_AV: step_n = crfb_pkg::SP_Z_ST;
      crfb_pkg::SP_Z_ST: done = 1'b1;
      default: ;
    endcase
  end

  // packing of the decision bit
  assign byte_n  = partial_q | (8'(bit_q) << bitpos_q);
  assign emit_ok = !out_valid_q || !out_stall_i;

  // control state machine
  always_comb begin
    state_d   = state_q;
    adv       = 1'b0;
    int_we    = 1'b0;
    mctl.cmd  = crfb_pkg::MC_NONE;
    mctl.xsel = xsel;
    mctl.neg  = neg;
    unique case (state_q)
      crfb_pkg::C_IDLE: begin
        if (in_acc && (mode_i == crfb_pkg::MODE_SAMPLE)) state_d = crfb_pkg::C_GAIN;
      end
      crfb_pkg::C_GAIN: begin
        mctl.cmd = crfb_pkg::MC_GAIN;
        state_d  = crfb_pkg::C_RD;
      end
      crfb_pkg::C_RD: begin
        if (kind == crfb_pkg::K_STORE || kind == crfb_pkg::K_BIT) begin
          int_we  = (kind == crfb_pkg::K_STORE);
          adv     = 1'b1;
          state_d = done ? crfb_pkg::C_PACK : crfb_pkg::C_RD;
        end else begin
          state_d = crfb_pkg::C_EX;
        end
      end
      crfb_pkg::C_EX: begin
        unique case (kind)
          crfb_pkg::K_LOAD: begin
            mctl.cmd = crfb_pkg::MC_LOAD;
            adv = 1'b1;
            state_d = crfb_pkg::C_RD;
          end
          crfb_pkg::K_ADD: begin
            mctl.cmd = crfb_pkg::MC_ADDI;
            adv = 1'b1;
            state_d = crfb_pkg::C_RD;
          end
          default: begin
            mctl.cmd = crfb_pkg::MC_LATCH;
            state_d = crfb_pkg::C_HI;
          end
        endcase
      end
      crfb_pkg::C_HI: begin
        mctl.cmd = crfb_pkg::MC_HI;
        state_d  = crfb_pkg::C_LO;
      end
      crfb_pkg::C_LO: begin
        mctl.cmd = crfb_pkg::MC_LO;
        state_d  = crfb_pkg::C_TRUNC;
      end
      crfb_pkg::C_TRUNC: begin
        mctl.cmd = crfb_pkg::MC_TRUNC;
        state_d  = crfb_pkg::C_ACC;
      end
      crfb_pkg::C_ACC: begin
        mctl.cmd = crfb_pkg::MC_ACC;
        adv      = 1'b1;
        state_d  = crfb_pkg::C_RD;
      end
      crfb_pkg::C_PACK: begin
        if (bitpos_q != 3'd7 || emit_ok) state_d = crfb_pkg::C_IDLE;
      end
      default: state_d = crfb_pkg::C_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crfb_pkg::C_IDLE;
      step_q      <= crfb_pkg::SP_DEC_LD;
      pidx_q      <= '0;
      bit_q       <= 1'b0;
      bitpos_q    <= '0;
      partial_q   <= '0;
      out_valid_q <= 1'b0;
      order_q     <= 4'd5;
      gain_q      <= 18'sd16384;
    end else begin
      state_q <= state_d;
      if (state_q == crfb_pkg::C_IDLE) begin
        step_q <= crfb_pkg::SP_DEC_LD;
      end else if (adv) begin
        step_q <= step_n;
        pidx_q <= pidx_n;
      end
      if (state_q == crfb_pkg::C_RD && kind == crfb_pkg::K_BIT) begin
        bit_q <= !acc[47];
      end
      // a new byte takes the output register, else a taken byte leaves it
      if (state_q == crfb_pkg::C_PACK && bitpos_q == 3'd7 && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == crfb_pkg::C_PACK) begin
        if (bitpos_q != 3'd7) begin
          partial_q <= byte_n;
          bitpos_q  <= bitpos_q + 3'd1;
        end else if (emit_ok) begin
          partial_q   <= '0;
          bitpos_q    <= '0;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          crfb_pkg::REG_FILTER_ORDER: order_q <= cfg_data_i[3:0];
          crfb_pkg::REG_INPUT_GAIN:   gain_q  <= $signed(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_i;
    end
    if (state_q == crfb_pkg::C_PACK && bitpos_q == 3'd7 && emit_ok) begin
      out_byte_q <= byte_n;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packed_byte_o = out_byte_q;

  crfb_ram #(
    .DEPTH (crfb_pkg::MAX_ORDER),
    .WIDTH (crfb_pkg::STATE_WIDTH)
  ) u_int_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (int_clr),
    .we_i    (int_we),
    .waddr_i (int_addr),
    .wdata_i (acc),
    .raddr_i (int_addr),
    .rdata_o (int_rdata)
  );

  crfb_ram #(
    .DEPTH (crfb_pkg::NUM_COEF),
    .WIDTH (crfb_pkg::COEF_WIDTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (1'b0),
    .we_i    (coef_we),
    .waddr_i (coef_index_i),
    .wdata_i (coef_value_i),
    .raddr_i (coef_addr),
    .rdata_o (coef_rdata)
  );

  crfb_mac u_mac (
    .clk_i       (clk_i),
    .ctrl_i      (mctl),
    .sample_i    (sample_q),
    .gain_i      (gain_q),
    .bit_i       (bit_q),
    .int_data_i  (int_rdata),
    .coef_data_i (coef_rdata),
    .acc_o       (acc)
  );

  // bit position only moves when a sample finishes
  `CRFB_ASSERT_NXT(a_bitpos_hold, state_q != crfb_pkg::C_PACK, $stable(bitpos_q))
  // a byte only appears after a packing step
  `CRFB_ASSERT_IMP(a_out_from_pack, $rose(out_valid_q), $past(state_q) == crfb_pkg::C_PACK)
  // pair index stays within the integrator range
  `CRFB_ASSERT_IMP(a_pidx_range, state_q != crfb_pkg::C_IDLE, pidx_q <= 4'(crfb_pkg::MAX_ORDER - 2))

endmodule

>>> tb/sv/crfb_delta_sigma_modulator_unit_tb.sv
`timescale 1ns / 1ps

module crfb_delta_sigma_modulator_unit_tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         mode_i;
  logic signed [23:0] sample_i;
  logic [4:0]         coef_index_i;
  logic signed [31:0] coef_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         packed_byte_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [17:0]        cfg_data_i;

  int bytes_checked;
  int samples_sent;
  bit quiet;

  crfb_delta_sigma_modulator_unit dut (.*);

  // bit-exact model of the modulator and the queue of bytes it will emit
  class modulator_scoreboard;
    logic [3:0]  order_reg;
    logic [17:0] gain_reg;
    longint      integ[crfb_pkg::MAX_ORDER];
    longint      coef[crfb_pkg::NUM_COEF];
    int          bit_pos;
    logic [7:0]  pending;
    logic [7:0]  byte_q[$];
    int          errors;

    function new();
      order_reg = 4'd5;
      gain_reg  = 18'd16384;
      foreach (integ[i]) integ[i] = 0;
      foreach (coef[i]) coef[i] = 0;
      bit_pos = 0;
      pending = 0;
      errors  = 0;
    endfunction

    // mismatch reporting
    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function void write_reg(logic [1:0] idx, logic [17:0] data);
      if (idx == crfb_pkg::REG_FILTER_ORDER) order_reg = data[3:0];
      else if (idx == crfb_pkg::REG_INPUT_GAIN) gain_reg = data;
    endfunction

    // x*c >> 27 toward zero, saturated to +-(2^63-1)
    function longint scale_q(longint x, longint c);
      logic signed [127:0] xx, cc, p;
      logic [127:0] m;
      xx = x;
      cc = c;
      p = xx * cc;
      m = (p < 0) ? -p : p;
      m = m >> (crfb_pkg::COEF_WIDTH - 5);
      if (m > 128'h7fff_ffff_ffff_ffff) m = 128'h7fff_ffff_ffff_ffff;
      return (p < 0) ? -longint'(m) : longint'(m);
    endfunction

    function longint clamp_state(logic signed [127:0] v);
      if (v > 128'sh7fff_ffff_ffff) return 64'sh7fff_ffff_ffff;
      if (v < -128'sh8000_0000_0000) return -64'sh8000_0000_0000;
      return longint'(v);
    endfunction

    function longint acc_add(longint a, longint t);
      logic signed [127:0] s;
      s = 128'(a) + 128'(t);
      return clamp_state(s);
    endfunction

    function void note_item(logic [1:0] mode, logic signed [23:0] smp,
                            logic [4:0] idx, logic signed [31:0] val);
      int ord;
      longint s, g, p, u, vv, acc;
      logic signed [127:0] y;
      bit b;
      if (mode == crfb_pkg::MODE_COEF) begin
        if (idx < crfb_pkg::NUM_COEF) coef[idx] = val;
        return;
      end
      if (mode == crfb_pkg::MODE_CLEAR) begin
        foreach (integ[i]) integ[i] = 0;
        return;
      end
      if (mode != crfb_pkg::MODE_SAMPLE) return;
      ord = order_reg;
      if (ord < 2) ord = 2;
      if (ord > crfb_pkg::MAX_ORDER) ord = crfb_pkg::MAX_ORDER;
      s = smp;
      g = $signed(gain_reg);
      p = s * g;
      u = (p < 0) ? -((-p) >>> 14) : (p >>> 14);
      y = 128'(integ[ord-1]) + 128'(scale_q(u, coef[crfb_pkg::B_BASE+ord]));
      b = (y >= 0);
      vv = b ? (64'sd1 <<< crfb_pkg::FRAC_BITS) : -(64'sd1 <<< crfb_pkg::FRAC_BITS);
      // resonator pairs from the top down
      for (int i = ord - 2; i >= 0; i -= 2) begin
        acc = integ[i];
        if (i >= 1) acc = acc_add(acc, integ[i-1]);
        acc = acc_add(acc, scale_q(u, coef[crfb_pkg::B_BASE+i]));
        acc = acc_add(acc, -scale_q(vv, coef[crfb_pkg::A_BASE+i]));
        acc = acc_add(acc, -scale_q(integ[i+1], coef[crfb_pkg::G_BASE+i/2]));
        integ[i] = acc;
        acc = integ[i+1];
        acc = acc_add(acc, integ[i]);
        acc = acc_add(acc, scale_q(u, coef[crfb_pkg::B_BASE+i+1]));
        acc = acc_add(acc, -scale_q(vv, coef[crfb_pkg::A_BASE+i+1]));
        integ[i+1] = acc;
      end
      // lone first integrator at odd order
      if (ord % 2 == 1) begin
        acc = integ[0];
        acc = acc_add(acc, scale_q(u, coef[crfb_pkg::B_BASE]));
        acc = acc_add(acc, -scale_q(vv, coef[crfb_pkg::A_BASE]));
        integ[0] = acc;
      end
      if (b) pending[bit_pos] = 1'b1;
      bit_pos = (bit_pos + 1) % 8;
      if (bit_pos == 0) begin
        byte_q.push_back(pending);
        pending = 0;
      end
    endfunction

    task check_byte(logic [7:0] got);
      logic [7:0] want;
      if (byte_q.size() == 0) begin
        report($sformatf("unexpected byte %02h", got));
        return;
      end
      want = byte_q.pop_front();
      if (got !== want) report($sformatf("packed_byte got %02h want %02h", got, want));
    endtask
  endclass

  modulator_scoreboard sb;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  // output beats
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_byte(packed_byte_o);
      bytes_checked++;
    end
  end

  // receiver stall bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end else begin
        repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end
    end
  end

  // one input beat, with an occasional idle burst ahead of it
  task automatic send_item(logic [1:0] mode, logic signed [23:0] smp,
                           logic [4:0] idx, logic signed [31:0] val);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    mode_i       = mode;
    sample_i     = smp;
    coef_index_i = idx;
    coef_value_i = val;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(mode, smp, idx, val);
    if (mode == crfb_pkg::MODE_SAMPLE) samples_sent++;
  endtask

  // wait for every byte due, then for the block to go quiet
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.byte_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [17:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coef();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
  endfunction

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'sh7fffff;
      1: return -24'sh800000;
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [3:0]  orders[10];
    logic [17:0] gains[10];
    int r;
    sb = new();
    bytes_checked = 0;
    samples_sent = 0;
    quiet = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = crfb_pkg::MODE_SAMPLE;
    sample_i = '0;
    coef_index_i = '0;
    coef_value_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = crfb_pkg::REG_FILTER_ORDER;
    cfg_data_i = '0;
    orders = '{4'd2, 4'd9, 4'd0, 4'd15, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd5};
    gains = '{18'd16384, 18'h20000, 18'h1ffff, 18'd0, 18'd8192,
              18'h3c000, 18'd12000, 18'd20000, 18'h3e000, 18'd16384};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: every coefficient slot, dead slots, unused mode, clear, sample extremes
    for (int i = 0; i < crfb_pkg::NUM_COEF; i++)
      send_item(crfb_pkg::MODE_COEF, '0, 5'(i), rand_coef());
    send_item(crfb_pkg::MODE_COEF, '0, 5'd23, 32'sh7fffffff);
    send_item(crfb_pkg::MODE_COEF, '0, 5'd31, -32'sh80000000);
    send_item(MODE_UNUSED, 24'sh7fffff, '0, '0);
    send_item(crfb_pkg::MODE_CLEAR, '0, '0, '0);
    send_item(crfb_pkg::MODE_SAMPLE, 24'sh7fffff, '0, '0);
    send_item(crfb_pkg::MODE_SAMPLE, -24'sh800000, '0, '0);
    send_item(crfb_pkg::MODE_SAMPLE, 24'sd0, '0, '0);
    send_item(crfb_pkg::MODE_SAMPLE, -24'sd1, '0, '0);
    for (int i = 0; i < 4; i++) send_item(crfb_pkg::MODE_SAMPLE, rand_sample(), '0, '0);
    drain();

    // random phases over order and gain settings
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(crfb_pkg::REG_FILTER_ORDER, {14'($urandom), orders[ph]});
      write_reg(crfb_pkg::REG_INPUT_GAIN, gains[ph]);
      write_reg(2'($urandom_range(2, 3)), 18'($urandom));
      if (ph == 9) quiet = 1;
      for (int n = 0; n < 140; n++) begin
        r = $urandom_range(0, 99);
        if (r < 84)
          send_item(crfb_pkg::MODE_SAMPLE, rand_sample(), 5'($urandom), $urandom);
        else if (r < 93)
          send_item(crfb_pkg::MODE_COEF, 24'($urandom), 5'($urandom_range(0, 31)),
                    rand_coef());
        else if (r < 97)
          send_item(crfb_pkg::MODE_CLEAR, 24'($urandom), 5'($urandom), $urandom);
        else send_item(MODE_UNUSED, 24'($urandom), 5'($urandom), $urandom);
      end
      drain();
    end

    $display("covered %0d samples over orders 0..15 and gain extremes, %0d bytes checked",
             samples_sent, bytes_checked);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
